/* sv/hocm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hocm_pkg
// Shared types, constants and saturating helpers for the central moment block.
// ----------------------------------------------------------------------------
package hocm_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int COORD_W        = 12;
  localparam int IN_DEPTH       = 4;
  localparam int OUT_DEPTH      = 2;

  localparam logic [2:0] CFG_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_M00    = 3'd2;
  localparam logic [2:0] CFG_M10    = 3'd3;
  localparam logic [2:0] CFG_M01    = 3'd4;
  localparam logic [2:0] CFG_SHIFT  = 3'd5;

  localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

  localparam logic [3:0] LAST_INDEX = 4'd10;
  localparam logic [3:0] FIRST_ORDER5 = 4'd5;

  typedef struct packed {
    logic [8:0]  width;
    logic [8:0]  height;
    logic [23:0] m00;
    logic [30:0] m10;
    logic [30:0] m01;
    logic [5:0]  shift;
  } cfg_t;

  typedef struct packed {
    logic [7:0]         pixel;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               first;
    logic               row_end;
    logic               frame_end;
  } item_t;

  typedef struct packed {
    logic [3:0]  index;
    logic [63:0] raw;
    logic [63:0] norm;
    logic [23:0] cx;
    logic [23:0] cy;
    logic        sat;
    logic        last;
  } res_t;

  typedef struct packed {
    logic        start;
    logic [95:0] a;
    logic [63:0] b;
    logic        neg;
    logic [4:0]  sh;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic        sat;
    logic [63:0] val;
  } mul_rsp_t;

  typedef struct packed {
    logic        sat;
    logic [63:0] val;
  } sat64_t;

  function automatic logic [63:0] mag(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic sat64_t pack_sat(input logic neg, input logic [63:0] hi,
                                      input logic [63:0] lo);
    sat64_t r;
    if (hi != 64'd0 || lo > (neg ? SMIN : SMAX)) begin
      r.sat = 1'b1;
      r.val = neg ? SMIN : SMAX;
    end else begin
      r.sat = 1'b0;
      r.val = neg ? (64'd0 - lo) : lo;
    end
    return r;
  endfunction

  function automatic sat64_t add_sat(input logic [63:0] a, input logic [63:0] b);
    sat64_t r;
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      r.sat = 1'b1;
      r.val = a[63] ? SMIN : SMAX;
    end else begin
      r.sat = 1'b0;
      r.val = s;
    end
    return r;
  endfunction

  // {power of x offset, power of y offset} for each output moment
  function automatic logic [5:0] moment_pq(input logic [3:0] i);
    logic [5:0] r;
    case (i)
      4'd0:    r = {3'd4, 3'd0};
      4'd1:    r = {3'd3, 3'd1};
      4'd2:    r = {3'd2, 3'd2};
      4'd3:    r = {3'd1, 3'd3};
      4'd4:    r = {3'd0, 3'd4};
      4'd5:    r = {3'd5, 3'd0};
      4'd6:    r = {3'd4, 3'd1};
      4'd7:    r = {3'd3, 3'd2};
      4'd8:    r = {3'd2, 3'd3};
      4'd9:    r = {3'd1, 3'd4};
      4'd10:   r = {3'd0, 3'd5};
      default: r = {3'd0, 3'd0};
    endcase
    return r;
  endfunction

endpackage

/* sv/high_order_central_moments.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// high_order_central_moments
// Central image moments of order 4 and 5 over a raster pixel stream.
//
//   channel   direction  handshake             payload
//   pixels    in         push / full           pixel
//   moments   out        pop / empty           moment_index, raw_moment,
//                                              normalized_moment, centroid_x,
//                                              centroid_y, saturated, last
//   config    in         cfg_we                cfg_index, cfg_data
//
// Items pass through a 4-deep queue to one shared sequencer with a 96x64
// multiplier built from six 32x32 products. A row end adds 25 products.
// The first pixel of a frame adds three 128-step divides for the centroid
// and scale, and an integer square root; the last pixel adds three
// 128-step divides per moment.
// Reset is synchronous; a full result queue stalls the sequencer only.
// ----------------------------------------------------------------------------
module high_order_central_moments import hocm_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  pixel,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  moment_index,
  output logic [63:0] raw_moment,
  output logic [63:0] normalized_moment,
  output logic [23:0] centroid_x,
  output logic [23:0] centroid_y,
  output logic        saturated,
  output logic        last
);

  cfg_t  cfg;
  logic  q_push;
  item_t q_data;
  logic  q_empty;
  item_t q_head;
  logic  q_pop;
  logic  r_push;
  res_t  r_data;
  res_t  r_head;

  hocm_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .pixel     (pixel),
    .q_full    (full),
    .q_push    (q_push),
    .q_data    (q_data),
    .cfg       (cfg)
  );

  hocm_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (IN_DEPTH)
  ) u_in_q (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (full),
    .pop       (q_pop),
    .pop_data  (q_head),
    .empty     (q_empty)
  );

  logic r_full;

  hocm_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_empty (q_empty),
    .in_data  (q_head),
    .in_pop   (q_pop),
    .out_full (r_full),
    .out_push (r_push),
    .out_data (r_data)
  );

  hocm_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst       (rst),
    .push      (r_push),
    .push_data (r_data),
    .full      (r_full),
    .pop       (pop),
    .pop_data  (r_head),
    .empty     (empty)
  );

  assign moment_index      = r_head.index;
  assign raw_moment        = r_head.raw;
  assign normalized_moment = r_head.norm;
  assign centroid_x        = r_head.cx;
  assign centroid_y        = r_head.cy;
  assign saturated         = r_head.sat;
  assign last              = r_head.last;

endmodule

/* sv/hocm_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hocm_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module hocm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* sv/hocm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hocm_front
// Configuration registers, pixel intake and raster position tagging.
// ----------------------------------------------------------------------------
module hocm_front import hocm_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        push,
  input  logic [7:0]  pixel,
  input  logic        q_full,
  output logic        q_push,
  output item_t       q_data,
  output cfg_t        cfg
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [CW-1:0] last_col;
  logic [RW-1:0] last_row;
  logic [CW-1:0] last_col_next;
  logic [RW-1:0] last_row_next;
  logic [CW-1:0] lc;
  logic [RW-1:0] lr;
  logic          first;
  logic          row_end;
  logic          frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= 9'd256;
      cfg.height <= 9'd256;
      cfg.m00    <= 24'd1;
      cfg.m10    <= '0;
      cfg.m01    <= '0;
      cfg.shift  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  cfg.width  <= cfg_data[8:0];
        CFG_HEIGHT: cfg.height <= cfg_data[8:0];
        CFG_M00:    cfg.m00    <= cfg_data[23:0];
        CFG_M10:    cfg.m10    <= cfg_data;
        CFG_M01:    cfg.m01    <= cfg_data;
        CFG_SHIFT:  cfg.shift  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // frame size clamped to the supported range
  always_comb begin
    if (cfg.width == 9'd0) begin
      last_col_next = '0;
    end else if (32'(cfg.width) > MAX_WIDTH) begin
      last_col_next = CW'(MAX_WIDTH - 1);
    end else begin
      last_col_next = CW'(cfg.width - 9'd1);
    end
    if (cfg.height == 9'd0) begin
      last_row_next = '0;
    end else if (32'(cfg.height) > MAX_HEIGHT) begin
      last_row_next = RW'(MAX_HEIGHT - 1);
    end else begin
      last_row_next = RW'(cfg.height - 9'd1);
    end
  end

  assign first     = (col == '0) && (row == '0);
  assign lc        = first ? last_col_next : last_col;
  assign lr        = first ? last_row_next : last_row;
  assign row_end   = (col == lc);
  assign frame_end = row_end && (row == lr);
  assign q_push    = push && !q_full;

  always_comb begin
    q_data.pixel     = pixel;
    q_data.col       = COORD_W'(col);
    q_data.row       = COORD_W'(row);
    q_data.first     = first;
    q_data.row_end   = row_end;
    q_data.frame_end = frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      last_col <= '0;
      last_row <= '0;
    end else if (q_push) begin
      if (first) begin
        last_col <= last_col_next;
        last_row <= last_row_next;
      end
      if (row_end) begin
        col <= '0;
        row <= frame_end ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

endmodule

/* sv/hocm_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hocm_mul
// Sign-magnitude 96x64 multiply from 32x32 partial products, then shift
// right and saturate to signed 64 bits.
// ----------------------------------------------------------------------------
module hocm_mul import hocm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic [95:0]  a_r;
  logic [63:0]  b_r;
  logic         neg_r;
  logic [4:0]   sh_r;
  logic         busy;
  logic [2:0]   ph;
  logic [63:0]  prod;
  logic [1:0]   prod_off;
  logic [127:0] acc;
  logic [31:0]  a_l;
  logic [31:0]  b_l;
  logic [1:0]   off;
  logic [127:0] prod_wide;
  logic [127:0] shifted;
  sat64_t       packed_res;
  logic         done_r;
  logic         sat_r;
  logic [63:0]  val_r;

  assign rsp = {done_r, sat_r, val_r};

  always_comb begin
    case (ph)
      3'd0:    begin a_l = a_r[31:0];  b_l = b_r[31:0];  off = 2'd0; end
      3'd1:    begin a_l = a_r[31:0];  b_l = b_r[63:32]; off = 2'd1; end
      3'd2:    begin a_l = a_r[63:32]; b_l = b_r[31:0];  off = 2'd1; end
      3'd3:    begin a_l = a_r[63:32]; b_l = b_r[63:32]; off = 2'd2; end
      3'd4:    begin a_l = a_r[95:64]; b_l = b_r[31:0];  off = 2'd2; end
      3'd5:    begin a_l = a_r[95:64]; b_l = b_r[63:32]; off = 2'd3; end
      default: begin a_l = '0;         b_l = '0;         off = 2'd0; end
    endcase
    case (prod_off)
      2'd0:    prod_wide = {64'd0, prod};
      2'd1:    prod_wide = {32'd0, prod, 32'd0};
      2'd2:    prod_wide = {prod, 64'd0};
      default: prod_wide = {prod[31:0], 96'd0};
    endcase
    shifted    = acc >> sh_r;
    packed_res = pack_sat(neg_r, shifted[127:64], shifted[63:0]);
  end

  always_ff @(posedge clk) begin
    prod     <= a_l * b_l;
    prod_off <= off;
    if (req.start && !busy) begin
      a_r   <= req.a;
      b_r   <= req.b;
      neg_r <= req.neg;
      sh_r  <= req.sh;
      acc   <= '0;
    end else if (busy && ph >= 3'd1 && ph <= 3'd6) begin
      acc <= acc + prod_wide;
    end
    if (busy && ph == 3'd7) begin
      sat_r <= packed_res.sat;
      val_r <= packed_res.val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      ph     <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        ph   <= '0;
      end else if (busy) begin
        if (ph == 3'd7) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end else begin
          ph <= ph + 1'b1;
        end
      end
    end
  end

endmodule

/* sv/hocm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hocm_back
// Sequencer: frame setup (centroid, scales), per-pixel power sums,
// per-row fold into the moments, and normalization at frame end.
// ----------------------------------------------------------------------------
module hocm_back import hocm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  in_empty,
  input  item_t in_data,
  output logic  in_pop,
  input  logic  out_full,
  output logic  out_push,
  output res_t  out_data
);

  localparam int NORM_SH = 46 - FRAC_BITS;

  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001,
    S_INIT  = 19'h00002,
    S_DIVX  = 19'h00004,
    S_DIVY  = 19'h00008,
    S_DIVR  = 19'h00010,
    S_SQ1   = 19'h00020,
    S_SQ2   = 19'h00040,
    S_PIX   = 19'h00080,
    S_PMUL  = 19'h00100,
    S_RI    = 19'h00200,
    S_RMUL  = 19'h00400,
    S_RADD  = 19'h00800,
    S_FI    = 19'h01000,
    S_NDIV  = 19'h02000,
    S_NPOST = 19'h04000,
    S_NMUL  = 19'h08000,
    S_OUT   = 19'h10000
  } state_t;

  state_t        state;
  item_t         it;
  logic [23:0]   d;
  logic [23:0]   cx;
  logic [23:0]   cy;
  logic [31:0]   r;
  logic [5:0]    shift;
  logic [63:0]   rps [6];
  logic [5:0]    row_sat;
  logic [63:0]   ms [11];
  logic [10:0]   mom_sat;
  logic [2:0]    k;
  logic [3:0]    i;
  logic [2:0]    qk;
  logic [1:0]    pass;
  logic [6:0]    dcnt;
  logic [63:0]   dx;
  logic [63:0]   dy;
  logic [63:0]   v;
  logic          s;
  logic [127:0]  num;
  logic [23:0]   rem;
  logic [63:0]   sv;
  logic [63:0]   sres;
  logic [63:0]   sbit;
  logic [63:0]   nu;
  logic          fsat;

  logic [24:0]   rem_sh;
  logic          ge;
  logic [23:0]   rem_next;
  logic [127:0]  num_next;
  logic [23:0]   quot_clamp;
  logic [5:0]    pq;
  logic [2:0]    pp;
  logic [2:0]    qn;
  logic [2:0]    rps_addr;
  logic [63:0]   rps_rd;
  logic [63:0]   dx_c;
  logic [63:0]   dy_c;
  sat64_t        add0;
  sat64_t        addk;
  sat64_t        addm;
  logic [63:0]   mu;
  logic          mu_neg;
  logic [63:0]   sq_sum;
  logic          sq_ge;
  logic          nq_ovf;
  sat64_t        npack;
  logic          pix_sat;
  mul_req_t      mreq;
  mul_rsp_t      mrsp;

  hocm_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  // one restoring divide step by the latched mass
  always_comb begin
    rem_sh     = {rem, num[127]};
    ge         = rem_sh >= {1'b0, d};
    rem_next   = ge ? 24'(rem_sh - {1'b0, d}) : rem_sh[23:0];
    num_next   = {num[126:0], ge};
    quot_clamp = (num_next[127:24] != '0) ? 24'hFF_FFFF : num_next[23:0];
  end

  always_comb begin
    pq       = moment_pq(i);
    pp       = pq[5:3];
    qn       = pq[2:0];
    rps_addr = (state == S_PMUL) ? k : pp;
    rps_rd   = rps[rps_addr];
    dx_c     = (64'(it.col) << FRAC_BITS) - {40'd0, cx};
    dy_c     = (64'(it.row) << FRAC_BITS) - {40'd0, cy};
    add0     = add_sat(rps[0], 64'(it.pixel) << FRAC_BITS);
    addk     = add_sat(rps_rd, mrsp.val);
    mu       = ms[i];
    mu_neg   = mu[63];
    addm     = add_sat(mu, v);
    sq_sum   = sres + sbit;
    sq_ge    = sv >= sq_sum;
    nq_ovf   = num[127:96] != '0;
    npack    = pack_sat(mu_neg, num[127:64], num[63:0]);
    // first product only marks its own sum; later ones mark all higher powers
    pix_sat  = addk.sat || (k != 3'd1 && mrsp.sat);
  end

  always_comb begin
    mreq = '0;
    case (state)
      S_PIX: begin
        mreq.start = 1'b1;
        mreq.a     = 96'(it.pixel);
        mreq.b     = mag(dx_c);
        mreq.neg   = dx_c[63];
        mreq.sh    = 5'd0;
      end
      S_PMUL: begin
        if (mrsp.done && k != 3'd5) begin
          mreq.start = 1'b1;
          mreq.a     = 96'(mag(mrsp.val));
          mreq.b     = mag(dx);
          mreq.neg   = mrsp.val[63] ^ dx[63];
          mreq.sh    = 5'(FRAC_BITS);
        end
      end
      S_RI: begin
        if (qn != 3'd0) begin
          mreq.start = 1'b1;
          mreq.a     = 96'(mag(rps_rd));
          mreq.b     = mag(dy);
          mreq.neg   = rps_rd[63] ^ dy[63];
          mreq.sh    = 5'(FRAC_BITS);
        end
      end
      S_RMUL: begin
        if (mrsp.done && qk != 3'd1) begin
          mreq.start = 1'b1;
          mreq.a     = 96'(mag(mrsp.val));
          mreq.b     = mag(dy);
          mreq.neg   = mrsp.val[63] ^ dy[63];
          mreq.sh    = 5'(FRAC_BITS);
        end
      end
      S_NPOST: begin
        if (i >= FIRST_ORDER5 && !nq_ovf) begin
          mreq.start = 1'b1;
          mreq.a     = num[95:0];
          mreq.b     = 64'(r);
          mreq.neg   = mu_neg;
          mreq.sh    = 5'd31;
        end
      end
      default: ;
    endcase
  end

  assign in_pop   = (state == S_IDLE) && !in_empty;
  assign out_push = (state == S_OUT) && !out_full;

  always_comb begin
    out_data.index = i;
    out_data.raw   = 64'($signed(mu) >>> shift);
    out_data.norm  = nu;
    out_data.cx    = cx;
    out_data.cy    = cy;
    out_data.sat   = fsat;
    out_data.last  = (i == LAST_INDEX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      row_sat <= '0;
      mom_sat <= '0;
      cx      <= '0;
      cy      <= '0;
      d       <= '0;
      r       <= '0;
      i       <= '0;
      for (int j = 0; j < 6; j++) begin
        rps[j] <= '0;
      end
      for (int j = 0; j < 11; j++) begin
        ms[j] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (!in_empty) begin
            it    <= in_data;
            state <= in_data.first ? S_INIT : S_PIX;
          end
        end
        S_INIT: begin
          d       <= (cfg.m00 == '0) ? 24'd1 : cfg.m00;
          shift   <= cfg.shift;
          row_sat <= '0;
          mom_sat <= '0;
          for (int j = 0; j < 6; j++) begin
            rps[j] <= '0;
          end
          for (int j = 0; j < 11; j++) begin
            ms[j] <= '0;
          end
          num   <= 128'(cfg.m10) << FRAC_BITS;
          rem   <= '0;
          dcnt  <= '0;
          state <= S_DIVX;
        end
        S_DIVX: begin
          num  <= num_next;
          rem  <= rem_next;
          dcnt <= dcnt + 1'b1;
          if (dcnt == 7'd127) begin
            cx    <= quot_clamp;
            num   <= 128'(cfg.m01) << FRAC_BITS;
            rem   <= '0;
            state <= S_DIVY;
          end
        end
        S_DIVY: begin
          num  <= num_next;
          rem  <= rem_next;
          dcnt <= dcnt + 1'b1;
          if (dcnt == 7'd127) begin
            cy    <= quot_clamp;
            num   <= 128'(1) << 62;
            rem   <= '0;
            state <= S_DIVR;
          end
        end
        S_DIVR: begin
          num  <= num_next;
          rem  <= rem_next;
          dcnt <= dcnt + 1'b1;
          if (dcnt == 7'd127) begin
            sv    <= num_next[63:0];
            sres  <= '0;
            sbit  <= 64'(1) << 62;
            state <= S_SQ1;
          end
        end
        S_SQ1: begin
          if (sbit > sv) begin
            sbit <= sbit >> 2;
          end else begin
            state <= S_SQ2;
          end
        end
        S_SQ2: begin
          if (sbit == '0) begin
            r     <= sres[31:0];
            state <= S_PIX;
          end else begin
            if (sq_ge) begin
              sv   <= sv - sq_sum;
              sres <= (sres >> 1) + sbit;
            end else begin
              sres <= sres >> 1;
            end
            sbit <= sbit >> 2;
          end
        end
        S_PIX: begin
          dx     <= dx_c;
          rps[0] <= add0.val;
          if (add0.sat) begin
            row_sat[0] <= 1'b1;
          end
          k     <= 3'd1;
          state <= S_PMUL;
        end
        S_PMUL: begin
          if (mrsp.done) begin
            rps[k] <= addk.val;
            if (k == 3'd1 && mrsp.sat) begin
              row_sat[1] <= 1'b1;
            end
            for (int j = 1; j < 6; j++) begin
              if (3'(j) >= k && pix_sat) begin
                row_sat[j] <= 1'b1;
              end
            end
            if (k == 3'd5) begin
              if (it.row_end) begin
                dy    <= dy_c;
                i     <= '0;
                state <= S_RI;
              end else begin
                state <= S_IDLE;
              end
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        S_RI: begin
          v     <= rps_rd;
          s     <= row_sat[pp];
          qk    <= qn;
          state <= (qn == 3'd0) ? S_RADD : S_RMUL;
        end
        S_RMUL: begin
          if (mrsp.done) begin
            v  <= mrsp.val;
            s  <= s | mrsp.sat;
            qk <= qk - 1'b1;
            if (qk == 3'd1) begin
              state <= S_RADD;
            end
          end
        end
        S_RADD: begin
          ms[i] <= addm.val;
          if (s || addm.sat) begin
            mom_sat[i] <= 1'b1;
          end
          if (i == LAST_INDEX) begin
            row_sat <= '0;
            for (int j = 0; j < 6; j++) begin
              rps[j] <= '0;
            end
            i     <= '0;
            state <= it.frame_end ? S_FI : S_IDLE;
          end else begin
            i     <= i + 1'b1;
            state <= S_RI;
          end
        end
        S_FI: begin
          num   <= 128'(mag(mu)) << NORM_SH;
          rem   <= '0;
          dcnt  <= '0;
          pass  <= '0;
          fsat  <= mom_sat[i];
          state <= S_NDIV;
        end
        // three divide passes by the mass give mu / m00^3
        S_NDIV: begin
          num  <= num_next;
          rem  <= rem_next;
          dcnt <= dcnt + 1'b1;
          if (dcnt == 7'd127) begin
            rem <= '0;
            if (pass == 2'd2) begin
              state <= S_NPOST;
            end else begin
              pass <= pass + 1'b1;
            end
          end
        end
        S_NPOST: begin
          if (i >= FIRST_ORDER5) begin
            if (nq_ovf) begin
              nu    <= mu_neg ? SMIN : SMAX;
              fsat  <= 1'b1;
              state <= S_OUT;
            end else begin
              state <= S_NMUL;
            end
          end else begin
            nu    <= npack.val;
            fsat  <= fsat | npack.sat;
            state <= S_OUT;
          end
        end
        S_NMUL: begin
          if (mrsp.done) begin
            nu    <= mrsp.val;
            fsat  <= fsat | mrsp.sat;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_full) begin
            if (i == LAST_INDEX) begin
              state <= S_IDLE;
            end else begin
              i     <= i + 1'b1;
              state <= S_FI;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
